// File: design/cubehash_byte_absorber_top_defines.svh
// Assertion macros used by the checker file of the byte absorber.
// Depends on nothing; take it in by `include with the bare file name.
`ifndef CUBEHASH_BYTE_ABSORBER_TOP_DEFINES_SVH
`define CUBEHASH_BYTE_ABSORBER_TOP_DEFINES_SVH

// Concurrent check that is held off while reset is high.
`define CBHA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cbha assertion failed");

// Concurrent check that is evaluated during reset as well.
`define CBHA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("cbha assertion failed");

`endif

// File: design/cbha_pkg.sv
// Types, constants and the round function of the CubeHash byte absorber.
// Depends on nothing; used by the interfaces and the top level.
`timescale 1ns / 1ps

package cbha_pkg;

   localparam int MODE_W    = 2;
   localparam int BYTE_W    = 8;
   localparam int DIGEST_W  = 64;
   localparam int ROUNDS_W  = 6;
   localparam int COUNT_W   = 10;
   localparam int PADDR_W   = 3;
   localparam int PDATA_W   = 32;

   localparam logic [MODE_W-1:0] MODE_INIT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ABSORB = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FINAL  = 2'd2;

   // Register index as decoded from paddr[2].
   localparam logic CSR_ROUNDS = 1'b0;
   localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 6'd16;

   localparam logic [31:0] HASH_BYTES  = 32'd8;
   localparam logic [31:0] BLOCK_BYTES = 32'd1;
   localparam logic [31:0] FINAL_MARK  = 32'h0000_0080;

   typedef logic [31:0] word_type;
   typedef word_type [15:0] half_type;

   typedef struct packed {
      half_type hi;
      half_type lo;
   } cube_type;

   function automatic word_type rotl(input word_type v, input logic [4:0] amt);
      return (v << amt) | (v >> (5'd0 - amt));
   endfunction

   function automatic cube_type half_round(input cube_type s, input logic [4:0] rot,
                                           input logic [3:0] swap_lo,
                                           input logic [3:0] swap_hi);
      cube_type r;
      half_type sum;
      half_type rot_sw;
      for (int i = 0; i < 16; i++) begin
         sum[i] = s.hi[i] + s.lo[i];
         rot_sw[4'(i) ^ swap_lo] = rotl(s.lo[i], rot);
      end
      for (int i = 0; i < 16; i++) begin
         r.lo[i] = rot_sw[i] ^ sum[i];
         r.hi[4'(i) ^ swap_hi] = sum[i];
      end
      return r;
   endfunction

   function automatic cube_type cube_round(input cube_type s);
      cube_type t;
      t = half_round(s, 5'd7, 4'd8, 4'd2);
      return half_round(t, 5'd11, 4'd4, 4'd1);
   endfunction

endpackage

// File: design/cbha_req_if.sv
// Command channel of the byte absorber: valid/ready plus mode and data byte.
// Depends on cbha_pkg.
`timescale 1ns / 1ps

interface cbha_req_if import cbha_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

// File: design/cbha_rsp_if.sv
// Digest channel of the byte absorber: valid/ready plus the 64-bit digest.
// Depends on cbha_pkg.
`timescale 1ns / 1ps

interface cbha_rsp_if import cbha_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DIGEST_W-1:0] digest;

   modport source (output valid, output digest, input ready);
   modport sink   (input valid, input digest, output ready);
endinterface

// File: design/cubehash_byte_absorber_top.sv
// Init runs 10*r rounds, absorb r rounds and finalize 11*r rounds before the digest (r = rounds_per_block).
// The block takes one command at a time; one full round per cycle through the single
//   shared round unit sets its rate, and a finalize also waits for the digest register.
// Reset (synchronous, active high): cube state to zero, rounds_per_block to 16,
//   sequencer idle, no digest pending.
// Depends on cbha_pkg, cbha_req_if and cbha_rsp_if.
`timescale 1ns / 1ps

module cubehash_byte_absorber_top import cbha_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   cbha_req_if.sink           req_chan,
   cbha_rsp_if.source         rsp_chan,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type            state_ff, state_in;
   cube_type             cube_ff, cube_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;      // rounds left in the current phase
   logic                 long_ff, long_in;    // current phase is the 10*r phase
   logic                 fin_ff, fin_in;      // command is a finalize
   logic [ROUNDS_W-1:0]  rounds_ff, rounds_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DIGEST_W-1:0]  digest_ff, digest_in;

   logic [COUNT_W-1:0]   short_cnt;
   logic [COUNT_W-1:0]   long_cnt;
   logic                 csr_write;
   cube_type             round_out;

   // 10*r as shift-and-add; make register changes only while the block is idle, which the block does not enforce.
   assign short_cnt = {{(COUNT_W-ROUNDS_W){1'b0}}, rounds_ff};
   assign long_cnt  = (short_cnt << 3) + (short_cnt << 1);

   // The one shared round unit: two half-rounds, used once per cycle while rounds remain.
   assign round_out = cube_round(cube_ff);

   assign csr_write = psel & penable & pwrite;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == CSR_ROUNDS) ?
                      {{(PDATA_W-ROUNDS_W){1'b0}}, rounds_ff} : '0;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.digest = digest_ff;

   always_comb begin
      state_in     = state_ff;
      cube_in      = cube_ff;
      cnt_in       = cnt_ff;
      long_in      = long_ff;
      fin_in       = fin_ff;
      rounds_in    = rounds_ff;
      rsp_valid_in = rsp_valid_ff;
      digest_in    = digest_ff;

      // Drop the digest once its transfer completes.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write && (paddr[2] == CSR_ROUNDS)) begin
         rounds_in = pwdata[ROUNDS_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_RUN;
               unique case (req_chan.mode)
                  MODE_INIT: begin
                     cube_in       = '0;
                     cube_in.lo[0] = HASH_BYTES;
                     cube_in.lo[1] = BLOCK_BYTES;
                     cube_in.lo[2] = {{(32-ROUNDS_W){1'b0}}, rounds_ff};
                     cnt_in        = long_cnt;
                     long_in       = 1'b1;
                     fin_in        = 1'b0;
                  end
                  MODE_ABSORB: begin
                     cube_in.lo[0] = cube_ff.lo[0] ^ {24'd0, req_chan.data_byte};
                     cnt_in        = short_cnt;
                     long_in       = 1'b0;
                     fin_in        = 1'b0;
                  end
                  MODE_FINAL: begin
                     cube_in.lo[0] = cube_ff.lo[0] ^ FINAL_MARK;
                     cnt_in        = short_cnt;
                     long_in       = 1'b0;
                     fin_in        = 1'b1;
                  end
                  default: begin
                     // Unused mode: pass through the sequencer with nothing to do.
                     cnt_in  = '0;
                     long_in = 1'b1;
                     fin_in  = 1'b0;
                  end
               endcase
            end
         end
         ST_RUN: begin
            priority if (cnt_ff != '0) begin
               // Advance one full round.
               cube_in = round_out;
               cnt_in  = cnt_ff - COUNT_W'(1);
            end else if (!long_ff && fin_ff) begin
               // End of the finalize short phase: mark and start the long phase.
               cube_in.hi[15] = cube_ff.hi[15] ^ 32'd1;
               cnt_in         = long_cnt;
               long_in        = 1'b1;
            end else if (!long_ff) begin
               state_in = ST_IDLE;
            end else if (fin_ff) begin
               // Hold the finished digest until the output register is free.
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_in = 1'b1;
                  digest_in    = {cube_ff.lo[1], cube_ff.lo[0]};
                  state_in     = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cube_ff      <= '0;
         cnt_ff       <= '0;
         long_ff      <= 1'b0;
         fin_ff       <= 1'b0;
         rounds_ff    <= ROUNDS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cube_ff      <= cube_in;
         cnt_ff       <= cnt_in;
         long_ff      <= long_in;
         fin_ff       <= fin_in;
         rounds_ff    <= rounds_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      digest_ff <= digest_in;
   end

endmodule

// File: design/cbha_checker.sv
// Port-level checks of the byte absorber, bound to the top level.
// Depends on cubehash_byte_absorber_top_defines.svh and the top level.
`timescale 1ns / 1ps
`include "cubehash_byte_absorber_top_defines.svh"

module cbha_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic pready
);

   // A command keeps the block busy for at least the following cycle.
   `CBHA_ASSERT(busy_after_cmd, clock, reset, (req_valid && req_ready) |=> !req_ready)
   // A digest only appears at the end of a command, never while idle.
   `CBHA_ASSERT(digest_from_run, clock, reset, $rose(rsp_valid) |-> $past(!req_ready))
   // A pending digest stays until its transfer.
   `CBHA_ASSERT(digest_held, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid)
   // Reset leaves no digest pending and the register port ready.
   `CBHA_ASSERT_ALWAYS(reset_clean, clock, reset |=> (!rsp_valid && pready))

endmodule

bind cubehash_byte_absorber_top cbha_checker u_cbha_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .pready    (pready)
);

// File: dv/cubehash_byte_absorber_top_tb.sv
// Self-checking bench for the CubeHash byte absorber: drives commands, predicts digests.
// Depends on cbha_pkg, cbha_req_if, cbha_rsp_if and cubehash_byte_absorber_top.
`timescale 1ns / 1ps

module cubehash_byte_absorber_top_tb import cbha_pkg::*; ();

   // The unused mode code: the block must swallow it without a digest.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   // Init and the long phase of finalize run this many times the per-byte round count.
   localparam int unsigned LONG_FACTOR = 10;
   // Receiver hold-off: after this many digests, keep ready low for a long stretch.
   localparam int unsigned HOLD_AFTER  = 12;
   localparam int unsigned HOLD_CYCLES = 1500;
   localparam int unsigned CYCLE_LIMIT = 1_500_000;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [BYTE_W-1:0] data_byte;
   } cbha_cmd_type;

   logic               clock;
   logic               reset;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   cbha_req_if req_chan ();
   cbha_rsp_if rsp_chan ();

   cubehash_byte_absorber_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Commands waiting to be offered, digests waiting to come back.
   cbha_cmd_type        cmd_queue[$];
   logic [DIGEST_W-1:0] pending_digests[$];

   // Mirror of the block: the cube and the per-byte round count.
   word_type            cube_state [32] = '{default: '0};
   logic [ROUNDS_W-1:0] rounds_cfg = ROUNDS_RESET;

   int          fail_count   = 0;
   int unsigned send_gap     = 0;
   int          send_calm    = 0;
   int unsigned rsp_stall    = 0;
   int unsigned rsp_hold     = 0;
   int          recv_calm    = 0;
   int unsigned digests_seen = 0;
   int unsigned cycle_count  = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // One half-round: add low half into high half, rotate and swap the low half,
   // xor it with the high half, then swap the high half.
   function automatic void half_step(input int unsigned rot, input int unsigned sw_lo,
                                     input int unsigned sw_hi);
      word_type shuffled [16];
      for (int i = 0; i < 16; i++) cube_state[i+16] += cube_state[i];
      for (int i = 0; i < 16; i++)
         shuffled[i ^ sw_lo] = (cube_state[i] << rot) | (cube_state[i] >> (32 - rot));
      for (int i = 0; i < 16; i++) cube_state[i] = shuffled[i] ^ cube_state[i+16];
      for (int i = 0; i < 16; i++) shuffled[i ^ sw_hi] = cube_state[i+16];
      for (int i = 0; i < 16; i++) cube_state[i+16] = shuffled[i];
   endfunction

   function automatic void cube_rounds(input int unsigned count);
      for (int unsigned n = 0; n < count; n++) begin
         half_step(7, 8, 2);
         half_step(11, 4, 1);
      end
   endfunction

   // Advance the mirror by one accepted command; queue a digest on finalize.
   function automatic void apply_command(input cbha_cmd_type cmd);
      int unsigned r;
      r = rounds_cfg;
      case (cmd.mode)
         MODE_INIT: begin
            foreach (cube_state[i]) cube_state[i] = '0;
            cube_state[0] = HASH_BYTES;
            cube_state[1] = BLOCK_BYTES;
            cube_state[2] = 32'(r);
            cube_rounds(LONG_FACTOR * r);
         end
         MODE_ABSORB: begin
            cube_state[0] ^= 32'(cmd.data_byte);
            cube_rounds(r);
         end
         MODE_FINAL: begin
            // Finalize leaves the cube as it is; later commands carry on from here.
            cube_state[0] ^= FINAL_MARK;
            cube_rounds(r);
            cube_state[31] ^= 32'd1;
            cube_rounds(LONG_FACTOR * r);
            pending_digests.push_back({cube_state[1], cube_state[0]});
         end
         default: ;  // unused mode: no state change, no digest
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // Gap before the next transfer, 0..15, with occasional runs of back-to-back traffic.
   function automatic int unsigned draw_wait(ref int calm_run);
      if (calm_run > 0) begin
         calm_run--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) calm_run = $urandom_range(10, 40);
      return $urandom_range(0, 15);
   endfunction

   function automatic void queue_cmd(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] b);
      cmd_queue.push_back(cbha_cmd_type'{mode: m, data_byte: b});
   endfunction

   // Mostly complete messages (init, bytes, finalize) with random content; the
   // rest is noise (any mode, including the unused one) or messages never finalized.
   function automatic void queue_traffic(input int unsigned n_items, input int unsigned max_len);
      int unsigned target;
      int unsigned kind;
      int unsigned len;
      target = cmd_queue.size() + n_items;
      while (cmd_queue.size() < target) begin
         kind = $urandom_range(0, 9);
         len  = $urandom_range(0, max_len);
         if (kind == 0) begin
            queue_cmd(MODE_W'($urandom_range(0, 3)), BYTE_W'($urandom));
         end else begin
            queue_cmd(MODE_INIT, BYTE_W'($urandom));
            repeat (len) queue_cmd(MODE_ABSORB, BYTE_W'($urandom));
            if (kind != 1) queue_cmd(MODE_FINAL, BYTE_W'($urandom));
         end
      end
   endfunction

   // Hold until every command is out and every digest back, then allow the
   // block to finish a command that yields no digest (it holds one at most).
   task automatic wait_for_drain();
      while (cmd_queue.size() != 0 || req_chan.valid || pending_digests.size() != 0)
         @(negedge clock);
      repeat (2 * (11 * int'(rounds_cfg) + 3) + 16) @(posedge clock);
   endtask

   // Write the round count while idle over the register port, then read it back.
   task automatic program_rounds(input logic [ROUNDS_W-1:0] value);
      wait_for_drain();
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {CSR_ROUNDS, 2'b00};
      pwdata  <= PDATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rounds_cfg = value;
      // Keep psel high and go straight into the read setup phase.
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== PDATA_W'(value)) begin
         $error("rounds_per_block mismatch: expected %0d, actual %0d", value, prdata);
         fail_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // ---------------------------------------------------------------- command driver

   // Offer the next command once the slot is free and the gap is over; predict each
   // transfer at the edge it happens. valid stays high across back-to-back transfers.
   always @(posedge clock) begin
      cbha_cmd_type next_cmd;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap       <= 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid)
            apply_command(cbha_cmd_type'{mode: req_chan.mode,
                                         data_byte: req_chan.data_byte});
         if (send_gap != 0) begin
            send_gap       <= send_gap - 1;
            req_chan.valid <= 1'b0;
         end else if (cmd_queue.size() != 0) begin
            next_cmd            = cmd_queue.pop_front();
            req_chan.valid     <= 1'b1;
            req_chan.mode      <= next_cmd.mode;
            req_chan.data_byte <= next_cmd.data_byte;
            send_gap           <= draw_wait(send_calm);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- digest monitor

   // Check each digest transfer against the oldest prediction; stall ready at
   // random, and once hold it low long enough for the block to back up.
   always @(posedge clock) begin
      int unsigned         stall_next;
      int unsigned         hold_next;
      logic [DIGEST_W-1:0] want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall      <= 0;
         rsp_hold       <= 0;
      end else begin
         stall_next = rsp_stall;
         hold_next  = rsp_hold;
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_digests.size() == 0) begin
               $error("digest transfer with nothing expected: actual %h", rsp_chan.digest);
               fail_count++;
            end else begin
               want = pending_digests.pop_front();
               if (rsp_chan.digest !== want) begin
                  $error("digest mismatch: expected %h, actual %h", want, rsp_chan.digest);
                  fail_count++;
               end
            end
            digests_seen++;
            stall_next = draw_wait(recv_calm);
            if (digests_seen == HOLD_AFTER) hold_next = HOLD_CYCLES;
         end
         if (hold_next != 0) begin
            hold_next--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_next != 0) begin
            stall_next--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
         rsp_stall <= stall_next;
         rsp_hold  <= hold_next;
      end
   end

   // ---------------------------------------------------------------- watchdog

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   // ---------------------------------------------------------------- test sequence

   initial begin
      reset              = 1'b1;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      req_chan.valid     = 1'b0;
      req_chan.mode      = MODE_INIT;
      req_chan.data_byte = '0;
      rsp_chan.ready     = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed, at the reset round count. Start without init: the cube is zero.
      queue_cmd(MODE_ABSORB, 8'hFF);
      queue_cmd(MODE_FINAL, 8'h00);
      queue_cmd(MODE_UNUSED, 8'hFF);
      // Init ignores its data byte.
      queue_cmd(MODE_INIT, 8'hFF);
      queue_cmd(MODE_ABSORB, 8'h00);
      queue_cmd(MODE_ABSORB, 8'hFF);
      queue_cmd(MODE_ABSORB, 8'h80);
      queue_cmd(MODE_ABSORB, 8'h01);
      queue_cmd(MODE_ABSORB, 8'h55);
      queue_cmd(MODE_ABSORB, 8'hAA);
      queue_cmd(MODE_FINAL, 8'hFF);
      // Finalize twice in a row, then carry on absorbing from the finalized cube.
      queue_cmd(MODE_FINAL, 8'h00);
      queue_cmd(MODE_ABSORB, 8'h7F);
      queue_cmd(MODE_UNUSED, 8'h00);
      queue_cmd(MODE_FINAL, 8'h5A);
      // Empty message.
      queue_cmd(MODE_INIT, 8'h00);
      queue_cmd(MODE_FINAL, 8'h00);

      // Random traffic over several round counts: in range, zero and above range.
      queue_traffic(400, 16);
      program_rounds(6'd1);
      queue_traffic(300, 16);
      program_rounds(6'd32);
      queue_traffic(150, 10);
      program_rounds(6'd0);
      queue_traffic(150, 16);
      program_rounds(6'd63);
      queue_traffic(60, 6);
      program_rounds(ROUNDS_W'($urandom_range(1, 32)));
      queue_traffic(120, 12);
      program_rounds(ROUNDS_W'($urandom_range(2, 31)));
      queue_traffic(120, 12);
      program_rounds(ROUNDS_RESET);
      queue_traffic(30, 8);

      wait_for_drain();
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
